/* rtl/gcdalu_pkg.sv */
package gcdalu_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int QUO_W   = DATA_W + FRAC_W;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int SHIFT_W = $clog2(DATA_W);
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int UPC_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_REM  = 3'd4,
		CMD_GCD  = 3'd5,
		CMD_LCM  = 3'd6,
		CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// datapath operation of one microcode step
	typedef enum logic [4:0] {
		UOP_FIN_ADD,
		UOP_FIN_SUB,
		UOP_MUL_MAG,
		UOP_FIN_MUL,
		UOP_DIV_FRAC,
		UOP_DIV_INT,
		UOP_DIV_STEP,
		UOP_FIN_DIV,
		UOP_FIN_REM,
		UOP_GCD_INIT,
		UOP_GCD_STEP,
		UOP_FIN_GCD,
		UOP_LCM_DIV,
		UOP_MUL_LCM,
		UOP_FIN_LCM,
		UOP_FIN_ZDIV,
		UOP_FIN_ZERO
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_B_ZERO,
		COND_AB_ZERO,
		COND_CNT_NZ,
		COND_GCD_RUN
	} cond_t;

	typedef struct packed {
		uop_t             uop;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             done;
	} ctrl_t;

	typedef struct packed {
		logic b_zero;
		logic ab_zero;
		logic cnt_nz;
		logic gcd_run;
	} flags_t;

	localparam logic [UPC_W-1:0] UA_ADD       = 5'd0;
	localparam logic [UPC_W-1:0] UA_SUB       = 5'd1;
	localparam logic [UPC_W-1:0] UA_MUL       = 5'd2;
	localparam logic [UPC_W-1:0] UA_MUL_FIN   = 5'd3;
	localparam logic [UPC_W-1:0] UA_DIV       = 5'd4;
	localparam logic [UPC_W-1:0] UA_DIV_LOOP  = 5'd5;
	localparam logic [UPC_W-1:0] UA_DIV_FIN   = 5'd6;
	localparam logic [UPC_W-1:0] UA_REM       = 5'd7;
	localparam logic [UPC_W-1:0] UA_REM_LOOP  = 5'd8;
	localparam logic [UPC_W-1:0] UA_REM_FIN   = 5'd9;
	localparam logic [UPC_W-1:0] UA_GCD       = 5'd10;
	localparam logic [UPC_W-1:0] UA_GCD_LOOP  = 5'd11;
	localparam logic [UPC_W-1:0] UA_GCD_FIN   = 5'd12;
	localparam logic [UPC_W-1:0] UA_LCM       = 5'd13;
	localparam logic [UPC_W-1:0] UA_LCM_GCD   = 5'd14;
	localparam logic [UPC_W-1:0] UA_LCM_DIV   = 5'd15;
	localparam logic [UPC_W-1:0] UA_LCM_DLOOP = 5'd16;
	localparam logic [UPC_W-1:0] UA_LCM_MUL   = 5'd17;
	localparam logic [UPC_W-1:0] UA_LCM_FIN   = 5'd18;
	localparam logic [UPC_W-1:0] UA_ZDIV      = 5'd19;
	localparam logic [UPC_W-1:0] UA_ZERO      = 5'd20;

	function automatic ctrl_t cw(uop_t uop, cond_t cond, logic [UPC_W-1:0] target,
			logic done);
		ctrl_t c;
		c.uop    = uop;
		c.cond   = cond;
		c.target = target;
		c.done   = done;
		return c;
	endfunction

	// microcode ROM
	function automatic ctrl_t ucode(logic [UPC_W-1:0] addr);
		ctrl_t c;
		case (addr)
			UA_ADD:       c = cw(UOP_FIN_ADD,  COND_NEXT,    UA_ADD,       1'b1);
			UA_SUB:       c = cw(UOP_FIN_SUB,  COND_NEXT,    UA_SUB,       1'b1);
			UA_MUL:       c = cw(UOP_MUL_MAG,  COND_NEXT,    UA_MUL,       1'b0);
			UA_MUL_FIN:   c = cw(UOP_FIN_MUL,  COND_NEXT,    UA_MUL_FIN,   1'b1);
			UA_DIV:       c = cw(UOP_DIV_FRAC, COND_B_ZERO,  UA_ZDIV,      1'b0);
			UA_DIV_LOOP:  c = cw(UOP_DIV_STEP, COND_CNT_NZ,  UA_DIV_LOOP,  1'b0);
			UA_DIV_FIN:   c = cw(UOP_FIN_DIV,  COND_NEXT,    UA_DIV_FIN,   1'b1);
			UA_REM:       c = cw(UOP_DIV_INT,  COND_B_ZERO,  UA_ZDIV,      1'b0);
			UA_REM_LOOP:  c = cw(UOP_DIV_STEP, COND_CNT_NZ,  UA_REM_LOOP,  1'b0);
			UA_REM_FIN:   c = cw(UOP_FIN_REM,  COND_NEXT,    UA_REM_FIN,   1'b1);
			UA_GCD:       c = cw(UOP_GCD_INIT, COND_NEXT,    UA_GCD,       1'b0);
			UA_GCD_LOOP:  c = cw(UOP_GCD_STEP, COND_GCD_RUN, UA_GCD_LOOP,  1'b0);
			UA_GCD_FIN:   c = cw(UOP_FIN_GCD,  COND_NEXT,    UA_GCD_FIN,   1'b1);
			UA_LCM:       c = cw(UOP_GCD_INIT, COND_AB_ZERO, UA_ZERO,      1'b0);
			UA_LCM_GCD:   c = cw(UOP_GCD_STEP, COND_GCD_RUN, UA_LCM_GCD,   1'b0);
			UA_LCM_DIV:   c = cw(UOP_LCM_DIV,  COND_NEXT,    UA_LCM_DIV,   1'b0);
			UA_LCM_DLOOP: c = cw(UOP_DIV_STEP, COND_CNT_NZ,  UA_LCM_DLOOP, 1'b0);
			UA_LCM_MUL:   c = cw(UOP_MUL_LCM,  COND_NEXT,    UA_LCM_MUL,   1'b0);
			UA_LCM_FIN:   c = cw(UOP_FIN_LCM,  COND_NEXT,    UA_LCM_FIN,   1'b1);
			UA_ZDIV:      c = cw(UOP_FIN_ZDIV, COND_NEXT,    UA_ZDIV,      1'b1);
			default:      c = cw(UOP_FIN_ZERO, COND_NEXT,    UA_ZERO,      1'b1);
		endcase
		return c;
	endfunction

	function automatic logic [UPC_W-1:0] entry(cmd_t cmd);
		logic [UPC_W-1:0] a;
		case (cmd)
			CMD_ADD: a = UA_ADD;
			CMD_SUB: a = UA_SUB;
			CMD_MUL: a = UA_MUL;
			CMD_DIV: a = UA_DIV;
			CMD_REM: a = UA_REM;
			CMD_GCD: a = UA_GCD;
			CMD_LCM: a = UA_LCM;
			default: a = UA_ZERO;
		endcase
		return a;
	endfunction

endpackage

/* rtl/gcdalu_if.sv */
interface gcdalu_req_if import gcdalu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;

	modport source (output valid, cmd, operand_a, operand_b, input ready);
	modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface gcdalu_rsp_if import gcdalu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result;
	logic signed [QUO_W-1:0]  quotient_fixed;
	logic [STAT_W-1:0]        status;

	modport source (output valid, result, quotient_fixed, status, input ready);
	modport sink   (input valid, result, quotient_fixed, status, output ready);
endinterface

/* rtl/gcdalu_seq.sv */
module gcdalu_seq import gcdalu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  cmd_t   cmd,
	input  flags_t flags,
	input  logic   hold,
	output ctrl_t  ctrl,
	output logic   fire,
	output logic   busy
);

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	seq_state_t       state_q;
	logic [UPC_W-1:0] upc_q;
	logic             taken;

	assign ctrl = ucode(upc_q);
	assign busy = (state_q == SEQ_RUN);
	// a final step waits while the output register is still full
	assign fire = busy && !(ctrl.done && hold);

	always_comb begin
		case (ctrl.cond)
			COND_B_ZERO:  taken = flags.b_zero;
			COND_AB_ZERO: taken = flags.ab_zero;
			COND_CNT_NZ:  taken = flags.cnt_nz;
			COND_GCD_RUN: taken = flags.gcd_run;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			upc_q   <= UA_ZERO;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						state_q <= SEQ_RUN;
						upc_q   <= entry(cmd);
					end
				end
				SEQ_RUN: begin
					if (fire) begin
						if (ctrl.done) begin
							state_q <= SEQ_IDLE;
						end else if (taken) begin
							upc_q <= ctrl.target;
						end else begin
							upc_q <= upc_q + UPC_W'(1);
						end
					end
				end
				default: state_q <= SEQ_IDLE;
			endcase
		end
	end

endmodule

/* rtl/integer_alu_gcd_lcm.sv */
// channel | dir | fields                            | transfer
// req     | in  | cmd, operand_a, operand_b         | valid & ready
// rsp     | out | result, quotient_fixed, status    | valid & ready
//
// One item at a time; req.ready is high while the microcode sequencer is idle.
// Divide and remainder run 48 restoring division steps; gcd runs a binary gcd
// loop; lcm runs that loop, then a restoring division and a multiply. A zero
// divisor, or lcm with a zero operand, goes straight to its final step.
// The result register frees the sequencer; a stalled rsp holds the last step.
// arst_n clears the sequencer and rsp.valid.
module integer_alu_gcd_lcm import gcdalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gcdalu_req_if.sink  req,
	gcdalu_rsp_if.source rsp
);

	logic [DATA_W-1:0]  a_q, b_q;
	logic [DATA_W-1:0]  x_q, y_q;
	logic [SHIFT_W-1:0] k_q;
	logic [DATA_W-1:0]  rem_q;
	logic [QUO_W-1:0]   dvd_q;
	logic [DATA_W-1:0]  dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  prod_q;

	logic               rsp_valid_q;
	logic [DATA_W-1:0]  rsp_result_q;
	logic [QUO_W-1:0]   rsp_quo_q;
	logic [STAT_W-1:0]  rsp_status_q;

	ctrl_t              ctrl;
	flags_t             flags;
	logic               fire, busy, req_fire, hold;

	logic [DATA_W-1:0]  ma, mb, gcd_val, mul_x;
	logic [PROD_W-1:0]  mul_p;
	logic [DATA_W:0]    trial, trial_diff;
	logic               trial_ge;
	logic [DATA_W-1:0]  sum, diff;
	logic               sign_x;
	logic               p_neg;

	logic [DATA_W-1:0]  fin_result;
	logic [QUO_W-1:0]   fin_quo;
	status_t            fin_status;

	assign req.ready   = !busy;
	assign req_fire    = req.valid && req.ready;
	assign hold        = rsp_valid_q && !rsp.ready;

	gcdalu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_fire),
		.cmd    (cmd_t'(req.cmd)),
		.flags  (flags),
		.hold   (hold),
		.ctrl   (ctrl),
		.fire   (fire),
		.busy   (busy)
	);

	assign ma = a_q[DATA_W-1] ? -a_q : a_q;
	assign mb = b_q[DATA_W-1] ? -b_q : b_q;

	assign flags.b_zero  = (b_q == '0);
	assign flags.ab_zero = (a_q == '0) || (b_q == '0);
	assign flags.cnt_nz  = (cnt_q != '0);
	assign flags.gcd_run = (x_q != '0) && (y_q != '0);

	// after the binary gcd loop one of x, y is zero
	assign gcd_val = (x_q | y_q) << k_q;

	assign mul_x = (ctrl.uop == UOP_MUL_LCM) ? dvd_q[DATA_W-1:0] : ma;
	assign mul_p = PROD_W'(mul_x) * PROD_W'(mb);

	// restoring division, one quotient bit per step
	assign trial      = {rem_q, dvd_q[QUO_W-1]};
	assign trial_ge   = (trial >= {1'b0, dsr_q});
	assign trial_diff = trial - {1'b0, dsr_q};

	assign sum    = a_q + b_q;
	assign diff   = a_q - b_q;
	assign sign_x = a_q[DATA_W-1] ^ b_q[DATA_W-1];
	assign p_neg  = sign_x && (prod_q != '0);

	always_comb begin
		fin_result = '0;
		fin_quo    = '0;
		fin_status = ST_OK;
		case (ctrl.uop)
			UOP_FIN_ADD: begin
				fin_result = sum;
				if (a_q[DATA_W-1] == b_q[DATA_W-1] && sum[DATA_W-1] != a_q[DATA_W-1])
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_SUB: begin
				fin_result = diff;
				if (a_q[DATA_W-1] != b_q[DATA_W-1] && diff[DATA_W-1] != a_q[DATA_W-1])
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_MUL: begin
				fin_result = p_neg ? -prod_q[DATA_W-1:0] : prod_q[DATA_W-1:0];
				// a magnitude of exactly 2^(w-1) fits only when negative
				if ((prod_q[PROD_W-1:DATA_W] != '0) ||
						(prod_q[DATA_W-1] && !(p_neg && prod_q[DATA_W-2:0] == '0)))
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_DIV: begin
				fin_quo = sign_x ? -dvd_q : dvd_q;
				if (!sign_x && dvd_q[QUO_W-1])
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_REM: begin
				fin_result = a_q[DATA_W-1] ? -rem_q : rem_q;
			end
			UOP_FIN_GCD: begin
				fin_result = gcd_val;
				if (gcd_val[DATA_W-1])
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_LCM: begin
				fin_result = prod_q[DATA_W-1:0];
				if (prod_q[PROD_W-1:DATA_W-1] != '0)
					fin_status = ST_OVERFLOW;
			end
			UOP_FIN_ZDIV: begin
				fin_status = ST_DIV_ZERO;
			end
			default: begin
				fin_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			a_q <= req.operand_a;
			b_q <= req.operand_b;
		end
		if (fire) begin
			case (ctrl.uop)
				UOP_MUL_MAG, UOP_MUL_LCM: begin
					prod_q <= mul_p;
				end
				UOP_DIV_FRAC: begin
					rem_q <= '0;
					dvd_q <= {ma, {FRAC_W{1'b0}}};
					dsr_q <= mb;
					cnt_q <= CNT_W'(QUO_W - 1);
				end
				UOP_DIV_INT: begin
					rem_q <= '0;
					dvd_q <= {{FRAC_W{1'b0}}, ma};
					dsr_q <= mb;
					cnt_q <= CNT_W'(QUO_W - 1);
				end
				UOP_LCM_DIV: begin
					rem_q <= '0;
					dvd_q <= {{FRAC_W{1'b0}}, ma};
					dsr_q <= gcd_val;
					cnt_q <= CNT_W'(QUO_W - 1);
				end
				UOP_DIV_STEP: begin
					rem_q <= trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
					dvd_q <= {dvd_q[QUO_W-2:0], trial_ge};
					cnt_q <= cnt_q - CNT_W'(1);
				end
				UOP_GCD_INIT: begin
					x_q <= ma;
					y_q <= mb;
					k_q <= '0;
				end
				UOP_GCD_STEP: begin
					if (flags.gcd_run) begin
						if (!x_q[0] && !y_q[0]) begin
							x_q <= x_q >> 1;
							y_q <= y_q >> 1;
							k_q <= k_q + SHIFT_W'(1);
						end else if (!x_q[0]) begin
							x_q <= x_q >> 1;
						end else if (!y_q[0]) begin
							y_q <= y_q >> 1;
						end else if (x_q >= y_q) begin
							x_q <= (x_q - y_q) >> 1;
						end else begin
							y_q <= (y_q - x_q) >> 1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire && ctrl.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.done) begin
			rsp_result_q <= fin_result;
			rsp_quo_q    <= fin_quo;
			rsp_status_q <= fin_status;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result         = rsp_result_q;
	assign rsp.quotient_fixed = rsp_quo_q;
	assign rsp.status         = rsp_status_q;

endmodule

/* verif/integer_alu_gcd_lcm_tb.sv */
`timescale 1ns / 100ps

module integer_alu_gcd_lcm_tb import gcdalu_pkg::*; ();

	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] INT_MAX = ~INT_MIN;
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [DATA_W-1:0] result;
		logic [QUO_W-1:0]  quotient_fixed;
		status_t           status;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t expected_q[$];
		int          mismatches;

		function logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function alu_result_t compute(cmd_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			alu_result_t r;
			logic        na, nb, neg;
			logic [63:0] ma, mb, prod, q, mag, lim;
			r.result         = '0;
			r.quotient_fixed = '0;
			r.status         = ST_OK;
			na  = a[DATA_W-1];
			nb  = b[DATA_W-1];
			ma  = '0;
			mb  = '0;
			ma[DATA_W-1:0] = na ? ~a + 1'b1 : a;
			mb[DATA_W-1:0] = nb ? ~b + 1'b1 : b;
			lim = 64'd1 << (DATA_W - 1);
			case (op)
				CMD_ADD: begin
					r.result = a + b;
					if (na == nb && r.result[DATA_W-1] != na)
						r.status = ST_OVERFLOW;
				end
				CMD_SUB: begin
					r.result = a - b;
					if (na != nb && r.result[DATA_W-1] != na)
						r.status = ST_OVERFLOW;
				end
				CMD_MUL: begin
					r.result = a * b;
					prod = ma * mb;
					neg  = (na ^ nb) && prod != 0;
					if (neg ? prod > lim : prod >= lim)
						r.status = ST_OVERFLOW;
				end
				CMD_DIV: begin
					if (mb == 0) begin
						r.status = ST_DIV_ZERO;
					end else begin
						// fraction bits by long division == floor(|a| * 2^F / |b|)
						q   = (ma << FRAC_W) / mb;
						neg = (na ^ nb) && q != 0;
						if (neg ? q > (64'd1 << (QUO_W - 1)) : q >= (64'd1 << (QUO_W - 1)))
							r.status = ST_OVERFLOW;
						mag = neg ? ~q + 1'b1 : q;
						r.quotient_fixed = mag[QUO_W-1:0];
					end
				end
				CMD_REM: begin
					if (mb == 0) begin
						r.status = ST_DIV_ZERO;
					end else begin
						mag = ma % mb;
						r.result = na ? ~mag[DATA_W-1:0] + 1'b1 : mag[DATA_W-1:0];
					end
				end
				CMD_GCD: begin
					mag = euclid(ma, mb);
					r.result = mag[DATA_W-1:0];
					if (mag >= lim)
						r.status = ST_OVERFLOW;
				end
				CMD_LCM: begin
					if (ma != 0 && mb != 0) begin
						prod = (ma / euclid(ma, mb)) * mb;
						r.result = prod[DATA_W-1:0];
						if (prod >= lim)
							r.status = ST_OVERFLOW;
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(cmd_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			expected_q.push_back(compute(op, a, b));
		endfunction

		function void check_result(logic [DATA_W-1:0] res, logic [QUO_W-1:0] quo,
				logic [STAT_W-1:0] st);
			alu_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h quo %h status %0d", res, quo, st);
				return;
			end
			e = expected_q.pop_front();
			if (res !== e.result || quo !== e.quotient_fixed || st !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: exp result %h quo %h status %0d, got %h quo %h status %0d",
						e.result, e.quotient_fixed, e.status, res, quo, st);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gcdalu_req_if req_ch();
	gcdalu_rsp_if rsp_ch();

	integer_alu_gcd_lcm dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	alu_scoreboard sb = new();
	int idle_phase = 0;
	bit stall_request = 1'b0;

	always #2 clk = ~clk;

	function automatic int send_idle_pct();
		return idle_phase == 0 ? 14 : idle_phase == 1 ? 81 : 0;
	endfunction

	function automatic int recv_idle_pct();
		return idle_phase == 0 ? 81 : idle_phase == 1 ? 14 : 0;
	endfunction

	task automatic send_item(cmd_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(op, a, b);
	endtask

	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $urandom_range(200) - 100;
			6: begin
				case ($urandom_range(5))
					0: v = '0;
					1: v = 1;
					2: v = '1;
					3: v = INT_MIN;
					4: v = INT_MAX;
					default: v = INT_MIN + 1;
				endcase
			end
			7: begin
				v = 1 << $urandom_range(DATA_W - 1);
				if ($urandom_range(1))
					v = -v;
			end
			8: v = $urandom_range(131071) - 65536;
			default: v = $urandom >> $urandom_range(DATA_W - 1);
		endcase
		return v;
	endfunction

	task automatic send_random();
		cmd_t              op;
		int                pick;
		logic [DATA_W-1:0] a, b, g;
		pick = $urandom_range(29);
		op   = pick < 28 ? cmd_t'(pick % 7) : CMD_NONE;
		a    = pick_operand();
		b    = pick_operand();
		// shared factor so gcd and lcm see nontrivial divisors
		if ((op == CMD_GCD || op == CMD_LCM) && $urandom_range(9) < 5) begin
			g = $urandom_range(1000, 1);
			a = g * $urandom_range(65535, 1);
			b = g * $urandom_range(65535, 1);
			if ($urandom_range(1))
				a = -a;
			if ($urandom_range(1))
				b = -b;
		end
		send_item(op, a, b);
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		int hold_left;
		bit stall_done;
		hold_left  = 0;
		stall_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.result, rsp_ch.quotient_fixed, rsp_ch.status);
			if (stall_request && !stall_done) begin
				stall_done = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct();
			end
		end
	end

	initial begin
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_NONE;
		req_ch.operand_a <= '0;
		req_ch.operand_b <= '0;
		arst_n           <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_ADD, INT_MAX, 1);
		send_item(CMD_ADD, INT_MIN, INT_MIN);
		send_item(CMD_SUB, INT_MIN, 1);
		send_item(CMD_SUB, 0, INT_MIN);
		send_item(CMD_SUB, INT_MAX, '1);
		send_item(CMD_MUL, INT_MIN, '1);
		send_item(CMD_MUL, 65536, 32768);
		send_item(CMD_MUL, -65536, 32768);
		send_item(CMD_MUL, INT_MAX, INT_MAX);
		send_item(CMD_DIV, 7, 0);
		send_item(CMD_DIV, INT_MIN, '1);
		send_item(CMD_DIV, INT_MIN, 1);
		send_item(CMD_DIV, -7, 2);
		send_item(CMD_DIV, 1, INT_MAX);
		send_item(CMD_REM, INT_MIN, '1);
		send_item(CMD_REM, -7, 2);
		send_item(CMD_REM, 7, 0);
		send_item(CMD_GCD, 0, 0);
		send_item(CMD_GCD, 0, -12);
		send_item(CMD_GCD, INT_MIN, INT_MIN);
		send_item(CMD_GCD, -48, 18);
		send_item(CMD_LCM, 0, 5);
		send_item(CMD_LCM, INT_MIN, INT_MIN);
		send_item(CMD_LCM, INT_MAX, INT_MAX - 1);
		send_item(CMD_LCM, -4, 6);
		send_item(CMD_NONE, INT_MAX, INT_MIN);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_phase = i < 420 ? 0 : i < 840 ? 1 : 2;
			if (i == 840)
				stall_request = 1'b1;
			send_random();
		end
		req_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
